[rtl/uartrb_pkg.sv]
// Package for the serial port receive and transmit byte queues.
// Holds request kinds, sizes, the result record and pointer helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uartrb_pkg;

  // Queue storage depth and derived widths.
  localparam int RxDepth = 256;
  localparam int TxDepth = 256;
  localparam int PtrW    = 8;
  localparam int SizeW   = 9;
  localparam int OvrW    = 16;
  localparam int CfgIdxW = 2;

  localparam logic [SizeW-1:0] RxSizeMin   = SizeW'(1);
  localparam logic [SizeW-1:0] TxSizeMin   = SizeW'(2);
  localparam logic [SizeW-1:0] RxSizeReset = SizeW'(RxDepth);
  localparam logic [SizeW-1:0] TxSizeReset = SizeW'(TxDepth);

  // Request kinds carried in req_type.
  typedef enum logic [2:0] {
    REQ_LINE_BYTE  = 3'd0,
    REQ_HOST_READ  = 3'd1,
    REQ_HOST_WRITE = 3'd2,
    REQ_TX_READY   = 3'd3,
    REQ_FLUSH      = 3'd4
  } req_kind_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRxSize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTxSize = CfgIdxW'(1);

  // One result record.
  typedef struct packed {
    logic [7:0]       data_out;
    logic             data_valid;
    logic [SizeW-1:0] rx_count;
    logic [SizeW-1:0] tx_space;
    logic             rx_full_flag;
    logic             tx_busy;
    logic [OvrW-1:0]  overrun_count;
    logic             rx_event;
  } res_t;

  // Clamp a written size into [lo, depth].
  function automatic logic [SizeW-1:0] fit_size(logic [SizeW-1:0] v, logic [SizeW-1:0] lo,
                                                 logic [SizeW-1:0] depth);
    logic [SizeW-1:0] s;
    s = v;
    if (s > depth) s = depth;
    if (s < lo) s = lo;
    return s;
  endfunction

  // Step a pointer forward, wrapping at the configured size.
  function automatic logic [PtrW-1:0] advance(logic [PtrW-1:0] p, logic [SizeW-1:0] size);
    logic [SizeW-1:0] nxt;
    nxt = {1'b0, p} + SizeW'(1);
    return (nxt >= size) ? '0 : nxt[PtrW-1:0];
  endfunction

  // Entries in use between read and write pointers.
  function automatic logic [SizeW-1:0] used(logic [PtrW-1:0] wr, logic [PtrW-1:0] rd,
                                             logic [SizeW-1:0] size);
    return (wr >= rd) ? ({1'b0, wr} - {1'b0, rd}) : (size - {1'b0, rd} + {1'b0, wr});
  endfunction

endpackage

`default_nettype wire

[rtl/uartrb_out_reg.sv]
// Output register of the serial queue block: holds one finished result.
// Depends on uartrb_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none

module uartrb_out_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                ready_o,
  input  wire uartrb_pkg::res_t res_i,
  output logic                valid_o,
  input  wire                 ready_i,
  output uartrb_pkg::res_t    res_o
);

  logic             valid_q;
  uartrb_pkg::res_t res_q;

  // Free when empty or when the held result leaves this cycle.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload capture.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[rtl/uart_rx_tx_ring_buffers_core.sv]
// An accepted request's result passes the result stage and then the output register.
// Throughput: one request per cycle while the output register is not held; the queue pointer
// update and the registered store read finish in the accept cycle, so nothing loops.
// Reset clears pointers, flags, the overrun counter and both sizes to 256 at once;
// the byte stores are not cleared and no clearing pass is needed.
// Top level of the serial port receive and transmit byte queues.
// Depends on uartrb_pkg and uartrb_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module uart_rx_tx_ring_buffers_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Request channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [2:0]                       req_type_i,
  input  wire  [7:0]                       data_in_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [7:0]                       data_out_o,
  output logic                             data_valid_o,
  output logic [uartrb_pkg::SizeW-1:0]     rx_count_o,
  output logic [uartrb_pkg::SizeW-1:0]     tx_space_o,
  output logic                             rx_full_flag_o,
  output logic                             tx_busy_o,
  output logic [uartrb_pkg::OvrW-1:0]      overrun_count_o,
  output logic                             rx_event_o,
  // Configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [uartrb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [uartrb_pkg::SizeW-1:0]     cfg_data_i
);

  localparam int PtrW  = uartrb_pkg::PtrW;
  localparam int SizeW = uartrb_pkg::SizeW;
  localparam int OvrW  = uartrb_pkg::OvrW;

  // Byte stores.
  logic [7:0] rx_mem [uartrb_pkg::RxDepth];
  logic [7:0] tx_mem [uartrb_pkg::TxDepth];
  logic [7:0] rx_rd_data_q, tx_rd_data_q;

  // Queue state.
  logic [PtrW-1:0]  rx_wr_ptr_q, rx_wr_ptr_d, rx_rd_ptr_q, rx_rd_ptr_d;
  logic             rx_full_q, rx_full_d;
  logic [PtrW-1:0]  tx_wr_ptr_q, tx_wr_ptr_d, tx_rd_ptr_q, tx_rd_ptr_d;
  logic             tx_running_q, tx_running_d;
  logic [OvrW-1:0]  tx_overruns_q, tx_overruns_d;
  logic [SizeW-1:0] rx_size_q, tx_size_q;

  // Result stage holding status next to the store read data.
  logic             s_valid_q;
  logic             s_data_valid_q, s_data_valid_d;
  logic             s_from_tx_q, s_from_tx_d;
  logic [SizeW-1:0] s_rx_count_q, s_tx_space_q;
  logic             s_rx_event_q, s_rx_event_d;

  logic             accept;
  logic             s_advance;
  logic             cfg_write;
  logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
  logic             o_ready;
  uartrb_pkg::res_t s_res, o_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;
  assign s_advance   = s_valid_q && o_ready;
  assign in_ready_o  = !s_valid_q || o_ready;
  assign accept      = in_valid_i && in_ready_o;

  // Next state of both queues for the accepted request.
  always_comb begin
    rx_wr_ptr_d    = rx_wr_ptr_q;
    rx_rd_ptr_d    = rx_rd_ptr_q;
    rx_full_d      = rx_full_q;
    tx_wr_ptr_d    = tx_wr_ptr_q;
    tx_rd_ptr_d    = tx_rd_ptr_q;
    tx_running_d   = tx_running_q;
    tx_overruns_d  = tx_overruns_q;
    s_data_valid_d = 1'b0;
    s_from_tx_d    = 1'b0;
    s_rx_event_d   = 1'b0;
    rx_wr_en       = 1'b0;
    rx_rd_en       = 1'b0;
    tx_wr_en       = 1'b0;
    tx_rd_en       = 1'b0;
    case (uartrb_pkg::req_kind_e'(req_type_i))
      uartrb_pkg::REQ_LINE_BYTE: begin
        s_rx_event_d = 1'b1;
        if (!rx_full_q) begin
          rx_wr_en    = 1'b1;
          rx_wr_ptr_d = uartrb_pkg::advance(rx_wr_ptr_q, rx_size_q);
          rx_full_d   = (rx_wr_ptr_d == rx_rd_ptr_q);
        end
      end
      uartrb_pkg::REQ_HOST_READ: begin
        if (rx_full_q || (rx_wr_ptr_q != rx_rd_ptr_q)) begin
          rx_rd_en       = 1'b1;
          s_data_valid_d = 1'b1;
          rx_full_d      = 1'b0;
          rx_rd_ptr_d    = uartrb_pkg::advance(rx_rd_ptr_q, rx_size_q);
        end
      end
      uartrb_pkg::REQ_HOST_WRITE: begin
        tx_wr_en     = 1'b1;
        tx_wr_ptr_d  = uartrb_pkg::advance(tx_wr_ptr_q, tx_size_q);
        tx_running_d = 1'b1;
        // A full queue loses its oldest byte.
        if (tx_wr_ptr_d == tx_rd_ptr_q) begin
          tx_overruns_d = tx_overruns_q + OvrW'(1);
          tx_rd_ptr_d   = uartrb_pkg::advance(tx_rd_ptr_q, tx_size_q);
        end
      end
      uartrb_pkg::REQ_TX_READY: begin
        if (tx_wr_ptr_q != tx_rd_ptr_q) begin
          tx_rd_en       = 1'b1;
          s_data_valid_d = 1'b1;
          s_from_tx_d    = 1'b1;
          tx_rd_ptr_d    = uartrb_pkg::advance(tx_rd_ptr_q, tx_size_q);
        end
        if (tx_wr_ptr_q == tx_rd_ptr_d) tx_running_d = 1'b0;
      end
      uartrb_pkg::REQ_FLUSH: begin
        rx_wr_ptr_d   = '0;
        rx_rd_ptr_d   = '0;
        rx_full_d     = 1'b0;
        tx_wr_ptr_d   = '0;
        tx_rd_ptr_d   = '0;
        tx_running_d  = 1'b0;
        tx_overruns_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Queue state registers; a size write empties its queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_ptr_q   <= '0;
      rx_rd_ptr_q   <= '0;
      rx_full_q     <= 1'b0;
      tx_wr_ptr_q   <= '0;
      tx_rd_ptr_q   <= '0;
      tx_running_q  <= 1'b0;
      tx_overruns_q <= '0;
      rx_size_q     <= uartrb_pkg::RxSizeReset;
      tx_size_q     <= uartrb_pkg::TxSizeReset;
    end else if (cfg_write) begin
      if (cfg_index_i == uartrb_pkg::CfgRxSize) begin
        rx_size_q   <= uartrb_pkg::fit_size(cfg_data_i, uartrb_pkg::RxSizeMin,
                                            uartrb_pkg::RxSizeReset);
        rx_wr_ptr_q <= '0;
        rx_rd_ptr_q <= '0;
        rx_full_q   <= 1'b0;
      end else if (cfg_index_i == uartrb_pkg::CfgTxSize) begin
        tx_size_q    <= uartrb_pkg::fit_size(cfg_data_i, uartrb_pkg::TxSizeMin,
                                             uartrb_pkg::TxSizeReset);
        tx_wr_ptr_q  <= '0;
        tx_rd_ptr_q  <= '0;
        tx_running_q <= 1'b0;
      end
    end else if (accept) begin
      rx_wr_ptr_q   <= rx_wr_ptr_d;
      rx_rd_ptr_q   <= rx_rd_ptr_d;
      rx_full_q     <= rx_full_d;
      tx_wr_ptr_q   <= tx_wr_ptr_d;
      tx_rd_ptr_q   <= tx_rd_ptr_d;
      tx_running_q  <= tx_running_d;
      tx_overruns_q <= tx_overruns_d;
    end
  end

  // Receive store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && rx_wr_en) begin
      rx_mem[rx_wr_ptr_q] <= data_in_i;
    end
    if (accept && rx_rd_en) begin
      rx_rd_data_q <= rx_mem[rx_rd_ptr_q];
    end
  end

  // Transmit store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && tx_wr_en) begin
      tx_mem[tx_wr_ptr_q] <= data_in_i;
    end
    if (accept && tx_rd_en) begin
      tx_rd_data_q <= tx_mem[tx_rd_ptr_q];
    end
  end

  // Result stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  // Result stage status, taken from the state after the request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_data_valid_q <= s_data_valid_d;
      s_from_tx_q    <= s_from_tx_d;
      s_rx_event_q   <= s_rx_event_d;
      s_rx_count_q   <= rx_full_d ? rx_size_q
                                  : uartrb_pkg::used(rx_wr_ptr_d, rx_rd_ptr_d, rx_size_q);
      s_tx_space_q   <= tx_size_q - uartrb_pkg::used(tx_wr_ptr_d, tx_rd_ptr_d, tx_size_q);
    end
  end

  // Status flags and the overrun counter are read after the accept edge, when
  // the stage holds, so they must be captured with the stage as well.
  logic s_rx_full_q, s_tx_busy_q;
  logic [OvrW-1:0] s_overruns_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_rx_full_q  <= rx_full_d;
      s_tx_busy_q  <= tx_running_d;
      s_overruns_q <= tx_overruns_d;
    end
  end

  // Assemble the result; the byte comes from whichever store was read.
  always_comb begin
    s_res.data_out      = s_data_valid_q ? (s_from_tx_q ? tx_rd_data_q : rx_rd_data_q) : 8'd0;
    s_res.data_valid    = s_data_valid_q;
    s_res.rx_count      = s_rx_count_q;
    s_res.tx_space      = s_tx_space_q;
    s_res.rx_full_flag  = s_rx_full_q;
    s_res.tx_busy       = s_tx_busy_q;
    s_res.overrun_count = s_overruns_q;
    s_res.rx_event      = s_rx_event_q;
  end

  uartrb_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_advance),
    .ready_o (o_ready),
    .res_i   (s_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (o_res)
  );

  assign data_out_o      = o_res.data_out;
  assign data_valid_o    = o_res.data_valid;
  assign rx_count_o      = o_res.rx_count;
  assign tx_space_o      = o_res.tx_space;
  assign rx_full_flag_o  = o_res.rx_full_flag;
  assign tx_busy_o       = o_res.tx_busy;
  assign overrun_count_o = o_res.overrun_count;
  assign rx_event_o      = o_res.rx_event;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the serial port receive and transmit byte queues.
// Depends on uartrb_pkg and uart_rx_tx_ring_buffers_core; keeps its own queue model.
`timescale 1ns / 1ps

module tb;
  import uartrb_pkg::*;

  // Request kinds that the block must treat as status-only no-ops.
  localparam logic [2:0] ReqSpareFirst = 3'd5;
  localparam logic [2:0] ReqSpareLast  = 3'd7;
  // A configuration index that maps to no register.
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgIdxW'(3);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] dat;
  } host_req_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid  = 1'b0;
  logic [2:0]          req_type  = '0;
  logic [7:0]          data_in   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [SizeW-1:0]    cfg_data  = '0;

  wire                 in_ready_o;
  wire                 out_valid_o;
  wire [7:0]           data_out_o;
  wire                 data_valid_o;
  wire [SizeW-1:0]     rx_count_o;
  wire [SizeW-1:0]     tx_space_o;
  wire                 rx_full_flag_o;
  wire                 tx_busy_o;
  wire [OvrW-1:0]      overrun_count_o;
  wire                 rx_event_o;
  wire                 cfg_ready_o;

  uart_rx_tx_ring_buffers_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type),
    .data_in_i       (data_in),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .data_out_o      (data_out_o),
    .data_valid_o    (data_valid_o),
    .rx_count_o      (rx_count_o),
    .tx_space_o      (tx_space_o),
    .rx_full_flag_o  (rx_full_flag_o),
    .tx_busy_o       (tx_busy_o),
    .overrun_count_o (overrun_count_o),
    .rx_event_o      (rx_event_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shared bench state.
  host_req_t req_backlog[$];
  res_t      want_results[$];
  int        n_accepted = 0;
  int        n_bad = 0;
  int        src_gap = 0;
  int        snk_gap = 0;
  bit        idling = 1'b1;
  bit        sink_hold = 1'b0;

  // Queue model state, at its reset values.
  logic [7:0]      rxq_mem [RxDepth];
  int              rxq_wr = 0;
  int              rxq_rd = 0;
  bit              rxq_full = 1'b0;
  int              rxq_len = RxDepth;
  logic [7:0]      txq_mem [TxDepth];
  int              txq_wr = 0;
  int              txq_rd = 0;
  bit              txq_run = 1'b0;
  int              txq_len = TxDepth;
  logic [OvrW-1:0] txq_lost = '0;

  function automatic int ring_next(int p, int len);
    return (p + 1 >= len) ? 0 : p + 1;
  endfunction

  function automatic int ring_fill(int wr, int rd, int len);
    return (wr >= rd) ? wr - rd : len - rd + wr;
  endfunction

  function automatic int clamp_size(logic [SizeW-1:0] v, int lo, int hi);
    int s;
    s = v;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s;
  endfunction

  // A size write empties its queue; stored bytes and the overrun count stay.
  function automatic void set_queue_size(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    if (idx == CfgRxSize) begin
      rxq_len  = clamp_size(val, RxSizeMin, RxDepth);
      rxq_wr   = 0;
      rxq_rd   = 0;
      rxq_full = 1'b0;
    end else if (idx == CfgTxSize) begin
      txq_len = clamp_size(val, TxSizeMin, TxDepth);
      txq_wr  = 0;
      txq_rd  = 0;
      txq_run = 1'b0;
    end
  endfunction

  // Apply one request to the queue model and return the status it reports.
  function automatic res_t uart_queues_step(logic [2:0] kind, logic [7:0] dat);
    res_t r;
    int   cnt;
    r = '0;
    case (kind)
      REQ_LINE_BYTE: begin
        r.rx_event = 1'b1;
        if (!rxq_full) begin
          rxq_mem[rxq_wr] = dat;
          rxq_wr = ring_next(rxq_wr, rxq_len);
          if (rxq_wr == rxq_rd) rxq_full = 1'b1;
        end
      end
      REQ_HOST_READ: begin
        if (rxq_full || rxq_wr != rxq_rd) begin
          r.data_out   = rxq_mem[rxq_rd];
          r.data_valid = 1'b1;
          rxq_full     = 1'b0;
          rxq_rd       = ring_next(rxq_rd, rxq_len);
        end
      end
      REQ_HOST_WRITE: begin
        txq_mem[txq_wr] = dat;
        txq_wr = ring_next(txq_wr, txq_len);
        // Writing into a full queue pushes out the oldest byte.
        if (txq_wr == txq_rd) begin
          txq_lost = txq_lost + 1'b1;
          txq_rd   = ring_next(txq_rd, txq_len);
        end
        txq_run = 1'b1;
      end
      REQ_TX_READY: begin
        if (txq_wr != txq_rd) begin
          r.data_out   = txq_mem[txq_rd];
          r.data_valid = 1'b1;
          txq_rd       = ring_next(txq_rd, txq_len);
        end
        if (txq_wr == txq_rd) txq_run = 1'b0;
      end
      REQ_FLUSH: begin
        rxq_wr   = 0;
        rxq_rd   = 0;
        rxq_full = 1'b0;
        txq_wr   = 0;
        txq_rd   = 0;
        txq_run  = 1'b0;
        txq_lost = '0;
      end
      default: ;
    endcase
    cnt = rxq_full ? rxq_len : ring_fill(rxq_wr, rxq_rd, rxq_len);
    r.rx_count      = SizeW'(cnt);
    r.tx_space      = SizeW'(txq_len - ring_fill(txq_wr, txq_rd, txq_len));
    r.rx_full_flag  = rxq_full;
    r.tx_busy       = txq_run;
    r.overrun_count = txq_lost;
    return r;
  endfunction

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_bad++;
    end
  endtask

  // Request driver: offers queued requests and predicts each accepted one.
  always @(posedge clk_i) begin : drive_reqs
    host_req_t nxt;
    logic      take;
    take = in_valid && (in_ready_o === 1'b1);
    if (take) begin
      want_results.push_back(uart_queues_step(req_type, data_in));
      n_accepted++;
      if (idling && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
    end
    if (in_valid && !take) begin
      // Keep the current request on the bus until it is taken.
    end else if (src_gap > 0) begin
      src_gap--;
      in_valid <= 1'b0;
    end else if (rst_n && req_backlog.size() > 0) begin
      nxt = req_backlog.pop_front();
      in_valid <= 1'b1;
      req_type <= nxt.kind;
      data_in  <= nxt.dat;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result monitor: checks every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_n && out_valid_o === 1'b1 && out_ready) begin
      if (want_results.size() == 0) begin
        $error("result arrived with no prediction pending");
        n_bad++;
      end else begin
        want = want_results.pop_front();
        cmp_field("data_out", want.data_out, data_out_o);
        cmp_field("data_valid", want.data_valid, data_valid_o);
        cmp_field("rx_count", want.rx_count, rx_count_o);
        cmp_field("tx_space", want.tx_space, tx_space_o);
        cmp_field("rx_full_flag", want.rx_full_flag, rx_full_flag_o);
        cmp_field("tx_busy", want.tx_busy, tx_busy_o);
        cmp_field("overrun_count", want.overrun_count, overrun_count_o);
        cmp_field("rx_event", want.rx_event, rx_event_o);
      end
    end
    if (snk_gap > 0) snk_gap--;
    else if (idling && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 13);
    out_ready <= !sink_hold && snk_gap == 0;
  end

  // Long receiver hold-off once traffic is under way, so the block backs up.
  initial begin
    while (n_accepted < 500) @(negedge clk_i);
    sink_hold = 1'b1;
    repeat (300) @(negedge clk_i);
    sink_hold = 1'b0;
  end

  // Run limit.
  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic add_req(logic [2:0] kind, logic [7:0] dat);
    host_req_t it;
    it.kind = kind;
    it.dat  = dat;
    req_backlog.push_back(it);
  endtask

  task automatic add_run(logic [2:0] kind, int n);
    repeat (n) add_req(kind, 8'($urandom));
  endtask

  // A random mix whose weights differ per phase, so queues fill and drain.
  task automatic add_random_mix(int n);
    int w_line, w_read, w_write, w_ready, pick;
    logic [2:0] kind;
    w_line  = $urandom_range(1, 8);
    w_read  = $urandom_range(1, 8);
    w_write = $urandom_range(1, 8);
    w_ready = $urandom_range(1, 8);
    repeat (n) begin
      pick = $urandom_range(0, 79);
      if (pick == 0) begin
        kind = REQ_FLUSH;
      end else if (pick == 1) begin
        kind = 3'($urandom_range(ReqSpareFirst, ReqSpareLast));
      end else begin
        pick = $urandom_range(0, w_line + w_read + w_write + w_ready - 1);
        if (pick < w_line) kind = REQ_LINE_BYTE;
        else if (pick < w_line + w_read) kind = REQ_HOST_READ;
        else if (pick < w_line + w_read + w_write) kind = REQ_HOST_WRITE;
        else kind = REQ_TX_READY;
      end
      add_req(kind, 8'($urandom));
    end
  endtask

  // Mostly small sizes, now and then the full depth or an out-of-range value.
  function automatic logic [SizeW-1:0] random_size_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SizeW'($urandom_range(RxDepth, 511));
      2: return SizeW'(RxDepth);
      default: return SizeW'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
    set_queue_size(idx, val);
  endtask

  // Returns once every request is taken and every result has been checked.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid || want_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Reset sizes: empty accesses, no-op kinds, both queues, flush.
    add_req(REQ_HOST_READ, 8'h00);
    add_req(REQ_TX_READY, 8'h00);
    for (int k = ReqSpareFirst; k <= ReqSpareLast; k++) add_req(3'(k), 8'hff);
    add_req(REQ_LINE_BYTE, 8'h00);
    add_req(REQ_LINE_BYTE, 8'hff);
    add_req(REQ_HOST_READ, 8'h00);
    add_req(REQ_HOST_READ, 8'hff);
    add_req(REQ_HOST_WRITE, 8'h00);
    add_req(REQ_HOST_WRITE, 8'hff);
    add_req(REQ_TX_READY, 8'h00);
    add_req(REQ_TX_READY, 8'h00);
    add_req(REQ_TX_READY, 8'h00);
    add_req(REQ_LINE_BYTE, 8'h5a);
    add_req(REQ_HOST_WRITE, 8'h3c);
    add_req(REQ_FLUSH, 8'h00);
    add_req(REQ_HOST_READ, 8'h00);

    // Smallest sizes: a one-entry receive queue and a one-byte transmit queue.
    wait_drained();
    write_reg(CfgRxSize, '0);
    write_reg(CfgTxSize, SizeW'(1));
    write_reg(CfgSpareIdx, '1);
    @(negedge clk_i);
    add_req(REQ_LINE_BYTE, 8'h11);
    add_req(REQ_LINE_BYTE, 8'h22);
    add_req(REQ_HOST_READ, 8'h00);
    add_req(REQ_HOST_READ, 8'h00);
    add_req(REQ_HOST_WRITE, 8'h01);
    add_req(REQ_HOST_WRITE, 8'h02);
    add_req(REQ_HOST_WRITE, 8'h03);
    add_req(REQ_TX_READY, 8'h00);
    add_req(REQ_TX_READY, 8'h00);

    // Oversized writes clamp to full depth; fill both queues past the top.
    wait_drained();
    write_reg(CfgRxSize, '1);
    write_reg(CfgTxSize, '1);
    @(negedge clk_i);
    add_run(REQ_LINE_BYTE, RxDepth + 2);
    add_run(REQ_HOST_WRITE, TxDepth + 2);
    add_run(REQ_HOST_READ, RxDepth + 1);
    add_run(REQ_TX_READY, TxDepth + 1);

    // Random sizes and mixes; the last phase runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_reg(CfgRxSize, random_size_value());
      write_reg(CfgTxSize, random_size_value());
      @(negedge clk_i);
      idling = (ph == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      add_random_mix(130);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_bad == 0 && want_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[uart_rx_tx_ring_buffers_core.f]
rtl/uartrb_pkg.sv
rtl/uartrb_out_reg.sv
rtl/uart_rx_tx_ring_buffers_core.sv
tb/tb.sv
